// File: rtl/msc_depuncturer_unit_assert.svh
// Assertion macros shared by the depuncturer RTL.
`ifndef MSC_DEPUNCTURER_UNIT_ASSERT_SVH
`define MSC_DEPUNCTURER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define MSC_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

`define MSC_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MSC_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg)

`define MSC_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg)

`endif

`endif

// File: rtl/msc_pkg.sv
`default_nettype none

package msc_pkg;

	localparam int SOFT_W      = 16;
	localparam int MAIN_W      = 18;
	localparam int POS_W       = MAIN_W + 1;
	localparam int SW_W        = 11;
	localparam int PAT_W       = 32;
	localparam int PAT_IDX_W   = 5;
	localparam int BLOCK_SHIFT = 7;
	localparam int TAIL_LEN    = 24;
	localparam int TIDX_W      = 5;
	localparam int WORD_W      = 17;
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int OUT_DATA_W  = 40;
	localparam int OUT_USER_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MAIN_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_BLOCKS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WORD     = 3'd5;

	localparam logic [MAIN_W-1:0] RST_MAIN_LENGTH    = 18'd6912;
	localparam logic [SW_W-1:0]   RST_SWITCH_BLOCKS  = 11'd51;
	localparam logic [PAT_W-1:0]  RST_PATTERN_FIRST  = 32'hFFFF_FFFF;
	localparam logic [PAT_W-1:0]  RST_PATTERN_SECOND = 32'hFFFF_FFFF;
	localparam logic [TAIL_LEN-1:0] RST_TAIL_PATTERN = 24'd3355443;
	localparam logic [WORD_W-1:0] RST_FRAME_WORD     = 17'd1734;

	typedef struct packed {
		logic [MAIN_W-1:0]   main_length;
		logic [SW_W-1:0]     switch_blocks;
		logic [PAT_W-1:0]    pattern_first;
		logic [PAT_W-1:0]    pattern_second;
		logic [TAIL_LEN-1:0] tail_pattern;
		logic [WORD_W-1:0]   frame_word;
	} cfg_t;

	typedef struct packed {
		logic [SOFT_W-1:0] sample;
		logic              sync;
	} entry_t;

	typedef struct packed {
		logic [SOFT_W-1:0] sample;
		logic              frame_start;
		logic [WORD_W-1:0] length_word;
		logic              run_last;
		logic              frame_end;
	} out_t;

	// Main positions pick a 32-bit pattern by 128-position block; tail positions
	// use the running index modulo 24 that the caller keeps beside the position.
	function automatic logic pos_kept(input logic [POS_W-1:0] p,
	                                  input logic [TIDX_W-1:0] t,
	                                  input cfg_t c);
		logic [PAT_W-1:0] pat;
		logic             kept;
		pat = (p[MAIN_W-1:BLOCK_SHIFT] < c.switch_blocks) ? c.pattern_first
		                                                  : c.pattern_second;
		if (p < {1'b0, c.main_length}) begin
			kept = pat[p[PAT_IDX_W-1:0]];
		end else begin
			kept = c.tail_pattern[t];
		end
		return kept;
	endfunction

endpackage

`default_nettype wire

// File: rtl/msc_depuncturer_unit.sv
// A request enters the front queue and is taken by the back end while it is
// idle; its results leave through a registered output.
// Throughput: one result per cycle within a run while the output side is ready;
// the back end takes a new request from the queue only between runs, and a
// dropped request gives no result. The single result port sets the pace.
// Reset (arst_n, asynchronous): registers to their defaults, idle, queue empty.
`default_nettype none

`include "msc_depuncturer_unit_assert.svh"

module msc_depuncturer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [msc_pkg::SOFT_W-1:0]     s_axis_tdata,  // [15:0] soft_value
	input  wire logic                           s_axis_tuser,  // [0] sync_mark
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [msc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [15:0] soft_out,
	                                                           // [32:16] length_word
	output logic [msc_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // [0] frame_start,
	                                                           // [1] frame_end
	output logic                                m_axis_tlast,  // run_last
	input  wire logic                           cfg_we,
	input  wire logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [msc_pkg::CFG_DATA_W-1:0] cfg_data
);

	msc_pkg::cfg_t   cfg_q;
	msc_pkg::entry_t q_entry;
	msc_pkg::out_t   out_item;
	logic            q_valid;
	logic            q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_length    <= msc_pkg::RST_MAIN_LENGTH;
			cfg_q.switch_blocks  <= msc_pkg::RST_SWITCH_BLOCKS;
			cfg_q.pattern_first  <= msc_pkg::RST_PATTERN_FIRST;
			cfg_q.pattern_second <= msc_pkg::RST_PATTERN_SECOND;
			cfg_q.tail_pattern   <= msc_pkg::RST_TAIL_PATTERN;
			cfg_q.frame_word     <= msc_pkg::RST_FRAME_WORD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msc_pkg::REG_MAIN_LENGTH:
					cfg_q.main_length <= cfg_data[msc_pkg::MAIN_W-1:0];
				msc_pkg::REG_SWITCH_BLOCKS:
					cfg_q.switch_blocks <= cfg_data[msc_pkg::SW_W-1:0];
				msc_pkg::REG_PATTERN_FIRST:
					cfg_q.pattern_first <= cfg_data[msc_pkg::PAT_W-1:0];
				msc_pkg::REG_PATTERN_SECOND:
					cfg_q.pattern_second <= cfg_data[msc_pkg::PAT_W-1:0];
				msc_pkg::REG_TAIL_PATTERN:
					cfg_q.tail_pattern <= cfg_data[msc_pkg::TAIL_LEN-1:0];
				msc_pkg::REG_FRAME_WORD:
					cfg_q.frame_word <= cfg_data[msc_pkg::WORD_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	msc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_soft   (s_axis_tdata),
		.in_sync   (s_axis_tuser),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_entry (q_entry)
	);

	msc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {
		(msc_pkg::OUT_DATA_W - msc_pkg::WORD_W - msc_pkg::SOFT_W)'(0),
		out_item.length_word,
		out_item.sample
	};
	assign m_axis_tuser = {out_item.frame_end, out_item.frame_start};
	assign m_axis_tlast = out_item.run_last;

	// The frame's final position always closes the run of its request.
	`MSC_ASSERT_IMP(a_end_closes_run, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "frame end without run end")

	// The length word goes out only on the frame's first position.
	`MSC_ASSERT_IMP(a_start_word, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[32:16] == cfg_q.frame_word) && !m_axis_tuser[1], "bad frame start result")

	// Inside a run the back end refills the output register as it drains.
	`MSC_ASSERT_NXT(a_run_continues, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "run broken before its last result")

endmodule

`default_nettype wire

// File: rtl/msc_front.sv
`default_nettype none

module msc_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [msc_pkg::SOFT_W-1:0] in_soft,
	input  wire logic                     in_sync,
	output logic                          pop_valid,
	input  wire logic                     pop,
	output msc_pkg::entry_t               pop_entry
);

	msc_pkg::entry_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            take;

	assign in_ready  = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_entry = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign take      = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{sample: in_soft, sync: in_sync};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/msc_back.sv
`default_nettype none

module msc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire msc_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	input  wire msc_pkg::entry_t q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output msc_pkg::out_t        out_item
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                           state_q;
	logic                             in_frame_q;
	logic [msc_pkg::POS_W-1:0]        pos_q;
	logic [msc_pkg::TIDX_W-1:0]       tidx_q;
	logic [msc_pkg::SOFT_W-1:0]       soft_q;
	logic                             used_q;
	logic [msc_pkg::CNT_W-1:0]        cnt_q;
	logic                             out_valid_q;
	msc_pkg::out_t                    out_q;

	logic [msc_pkg::POS_W-1:0]  total;
	logic [msc_pkg::POS_W-1:0]  pos_nxt;
	logic [msc_pkg::TIDX_W-1:0] tidx_nxt;
	logic                       kept_cur;
	logic                       kept_nxt;
	logic                       used_after;
	logic                       at_end;
	logic                       hit_limit;
	logic                       last;
	logic                       slot_free;
	logic                       emit;
	logic                       at_start;

	assign total    = {1'b0, cfg.main_length} + msc_pkg::POS_W'(msc_pkg::TAIL_LEN);
	assign pos_nxt  = pos_q + 1'b1;
	assign tidx_nxt = (tidx_q == msc_pkg::TIDX_W'(msc_pkg::TAIL_LEN - 1))
	                  ? '0 : tidx_q + 1'b1;
	assign kept_cur = msc_pkg::pos_kept(pos_q, tidx_q, cfg);
	assign kept_nxt = msc_pkg::pos_kept(pos_nxt, tidx_nxt, cfg);

	// A run stops after this position if the frame ends, the result limit is
	// reached, or the following position would need a second soft input.
	assign used_after = used_q | kept_cur;
	assign at_end     = (pos_q == total - 1'b1);
	assign hit_limit  = (cnt_q == msc_pkg::CNT_W'(msc_pkg::MAX_RESULTS - 1));
	assign last       = at_end | hit_limit | (used_after & kept_nxt);
	assign at_start   = (pos_q == '0);

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_RUN) && slot_free;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.sample      <= kept_cur ? soft_q : '0;
			out_q.frame_start <= at_start;
			out_q.length_word <= at_start ? cfg.frame_word : '0;
			out_q.run_last    <= last;
			out_q.frame_end   <= at_end;
		end
		if (q_pop) begin
			soft_q <= q_entry.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_frame_q  <= 1'b0;
			pos_q       <= '0;
			tidx_q      <= '0;
			used_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					used_q <= 1'b0;
					cnt_q  <= '0;
					if (q_valid) begin
						if (in_frame_q) begin
							// The frame may have been shortened by a length rewrite.
							if (pos_q >= total) begin
								in_frame_q <= 1'b0;
							end else begin
								state_q <= ST_RUN;
							end
						end else if (q_entry.sync) begin
							in_frame_q <= 1'b1;
							pos_q      <= '0;
							tidx_q     <= '0;
							state_q    <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (slot_free) begin
						pos_q  <= pos_nxt;
						tidx_q <= tidx_nxt;
						cnt_q  <= cnt_q + 1'b1;
						used_q <= used_after;
						if (last) begin
							state_q <= ST_IDLE;
						end
						if (at_end) begin
							in_frame_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: dv/msc_depuncturer_unit_checker.sv
module msc_depuncturer_unit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [msc_pkg::SOFT_W-1:0]     s_axis_tdata,  // [15:0] soft_value
	input  logic                           s_axis_tuser,  // [0] sync_mark
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [msc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] soft_out,
	                                                      // [32:16] length_word
	input  logic [msc_pkg::OUT_USER_W-1:0] m_axis_tuser,  // [0] frame_start,
	                                                      // [1] frame_end
	input  logic                           m_axis_tlast,  // run_last
	input  logic                           cfg_we,
	input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending,
	output logic                           frame_open
);
	import msc_pkg::*;

	cfg_t             regs;
	logic             framing;
	logic [POS_W-1:0] next_pos;
	out_t             expected_q[$];
	out_t             got;
	out_t             want;

	function automatic logic pos_keeps(input logic [POS_W-1:0] p);
		logic [PAT_W-1:0] pat;
		if (p < {1'b0, regs.main_length}) begin
			pat = ((p >> BLOCK_SHIFT) < regs.switch_blocks) ? regs.pattern_first
			                                                : regs.pattern_second;
			return pat[p[PAT_IDX_W-1:0]];
		end
		return regs.tail_pattern[p % TAIL_LEN];
	endfunction

	// Emits punctured positions up to and including the kept one that takes this
	// request, then the punctured run behind it, capped at the result limit and the frame end.
	task automatic predict_request(input logic [SOFT_W-1:0] sample, input logic sync);
		logic [POS_W-1:0] span;
		logic             kept;
		logic             taken;
		logic             have;
		int               n;
		out_t             held;
		out_t             cur;
		span = {1'b0, regs.main_length} + POS_W'(TAIL_LEN);
		taken = 1'b0;
		have = 1'b0;
		n = 0;
		held = '0;
		if (!framing) begin
			if (!sync)
				return;
			framing = 1'b1;
			next_pos = '0;
		end
		// A frame cut short by a smaller main length ends here with no output.
		if (next_pos >= span) begin
			framing = 1'b0;
			return;
		end
		while (n < MAX_RESULTS && next_pos < span) begin
			kept = pos_keeps(next_pos);
			if (kept && taken)
				break;
			taken = taken | kept;
			cur.sample = kept ? sample : '0;
			cur.frame_start = (next_pos == '0);
			cur.length_word = (next_pos == '0) ? regs.frame_word : '0;
			cur.run_last = 1'b0;
			cur.frame_end = (next_pos == span - 1'b1);
			if (have)
				expected_q.push_back(held);
			held = cur;
			have = 1'b1;
			next_pos++;
			n++;
		end
		if (next_pos == span)
			framing = 1'b0;
		if (have) begin
			held.run_last = 1'b1;
			expected_q.push_back(held);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.main_length = RST_MAIN_LENGTH;
			regs.switch_blocks = RST_SWITCH_BLOCKS;
			regs.pattern_first = RST_PATTERN_FIRST;
			regs.pattern_second = RST_PATTERN_SECOND;
			regs.tail_pattern = RST_TAIL_PATTERN;
			regs.frame_word = RST_FRAME_WORD;
			framing = 1'b0;
			next_pos = '0;
			expected_q.delete();
			mismatches <= 0;
			pending <= 0;
			frame_open <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAIN_LENGTH:    regs.main_length = cfg_data[MAIN_W-1:0];
					REG_SWITCH_BLOCKS:  regs.switch_blocks = cfg_data[SW_W-1:0];
					REG_PATTERN_FIRST:  regs.pattern_first = cfg_data[PAT_W-1:0];
					REG_PATTERN_SECOND: regs.pattern_second = cfg_data[PAT_W-1:0];
					REG_TAIL_PATTERN:   regs.tail_pattern = cfg_data[TAIL_LEN-1:0];
					REG_FRAME_WORD:     regs.frame_word = cfg_data[WORD_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.sample = m_axis_tdata[SOFT_W-1:0];
				got.length_word = m_axis_tdata[SOFT_W +: WORD_W];
				got.frame_start = m_axis_tuser[0];
				got.frame_end = m_axis_tuser[1];
				got.run_last = m_axis_tlast;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result soft=%0d start=%b word=%0d last=%b end=%b",
						$time, $signed(got.sample), got.frame_start, got.length_word,
						got.run_last, got.frame_end);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: expected soft=%0d start=%b word=%0d last=%b end=%b",
							$time, $signed(want.sample), want.frame_start, want.length_word,
							want.run_last, want.frame_end);
						$display("%0t: actual   soft=%0d start=%b word=%0d last=%b end=%b",
							$time, $signed(got.sample), got.frame_start, got.length_word,
							got.run_last, got.frame_end);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tdata, s_axis_tuser);
			pending <= expected_q.size();
			frame_open <= framing;
		end
	end

endmodule

// File: dv/msc_depuncturer_unit_test.sv
module msc_depuncturer_unit_test;
	import msc_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 280;
	localparam int PHASE_ITEMS  = 35;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [SOFT_W-1:0]     s_axis_tdata;   // [15:0] soft_value
	logic                  s_axis_tuser;   // [0] sync_mark
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // [15:0] soft_out, [32:16] length_word
	logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] frame_start, [1] frame_end
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   mismatches;
	int   pending;
	logic frame_open;
	logic steady;
	int   idle_cycles;
	cfg_t plan;

	msc_depuncturer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	msc_depuncturer_unit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.frame_open    (frame_open)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [PAT_W-1:0] random_pattern();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom() & $urandom();
			// Very sparse patterns make long punctured runs that hit the result limit.
			3: return $urandom() & $urandom() & $urandom() & $urandom();
			default: return $urandom();
		endcase
	endfunction

	// Writes every register, plus the two unused indexes, which must be ignored.
	task automatic apply_settings(input cfg_t c);
		logic [CFG_DATA_W-1:0] value;
		for (int idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
			case (CFG_IDX_W'(idx))
				REG_MAIN_LENGTH:    value = CFG_DATA_W'(c.main_length);
				REG_SWITCH_BLOCKS:  value = CFG_DATA_W'(c.switch_blocks);
				REG_PATTERN_FIRST:  value = c.pattern_first;
				REG_PATTERN_SECOND: value = c.pattern_second;
				REG_TAIL_PATTERN:   value = CFG_DATA_W'(c.tail_pattern);
				REG_FRAME_WORD:     value = CFG_DATA_W'(c.frame_word);
				default:            value = $urandom();
			endcase
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(idx);
			cfg_data <= value;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(input logic [SOFT_W-1:0] sample, input logic sync);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sample;
		s_axis_tuser <= sync;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops sending and waits for every expected result, then gives a dropped
	// request time to leave the pipeline.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL msc_depuncturer_unit");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int                counted;
		int                phase_count;
		logic              live;
		logic              sync;
		logic [SOFT_W-1:0] sample;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tail-only frame: the frame start lands on the first tail position.
		plan.main_length = '0;
		plan.switch_blocks = SW_W'(3);
		plan.pattern_first = '1;
		plan.pattern_second = '0;
		plan.tail_pattern = 24'h800001;
		plan.frame_word = '1;
		apply_settings(plan);
		send_item(16'h1234, 1'b0);
		send_item(16'h8000, 1'b1);
		send_item(16'h7FFF, 1'b0);
		send_item(16'hFFFF, 1'b0);
		settle();

		// Everything punctured: the first request runs into the result limit, the
		// second sees the frame end before a kept position and carries a sync that
		// must be taken as plain data.
		plan.main_length = 18'd100;
		plan.switch_blocks = '0;
		plan.pattern_first = '0;
		plan.pattern_second = '0;
		plan.tail_pattern = '0;
		plan.frame_word = '0;
		apply_settings(plan);
		send_item(16'h0001, 1'b1);
		send_item(16'hFFFE, 1'b1);
		settle();

		// First pattern for block zero only, then the second pattern and the tail.
		plan.main_length = 18'd260;
		plan.switch_blocks = SW_W'(1);
		plan.pattern_first = 32'h0000_0001;
		plan.pattern_second = 32'h8000_0001;
		plan.tail_pattern = 24'h000001;
		plan.frame_word = 17'h0AAAA;
		apply_settings(plan);
		for (int i = 0; i < 14; i++)
			send_item(i[0] ? 16'h7FFF : 16'h8000, i == 0);
		settle();

		// Longest frame, then shrink it under the current position so that the
		// next request ends the frame with nothing sent.
		plan.main_length = '1;
		plan.switch_blocks = '1;
		plan.pattern_first = '0;
		plan.pattern_second = '1;
		plan.tail_pattern = '1;
		plan.frame_word = 17'h15555;
		apply_settings(plan);
		send_item(16'h5A5A, 1'b1);
		settle();
		plan.main_length = 18'd1;
		apply_settings(plan);
		send_item(16'hA5A5, 1'b0);
		send_item(16'h0F0F, 1'b0);
		settle();

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: plan.main_length = '0;
				1: plan.main_length = MAIN_W'($urandom_range(400, 700));
				default: plan.main_length = MAIN_W'($urandom_range(1, 160));
			endcase
			case ($urandom_range(0, 5))
				0: plan.switch_blocks = '1;
				default: plan.switch_blocks = SW_W'($urandom_range(0, 4));
			endcase
			plan.pattern_first = random_pattern();
			plan.pattern_second = random_pattern();
			plan.tail_pattern = TAIL_LEN'(random_pattern());
			plan.frame_word = WORD_W'($urandom_range(0, 131071));
			apply_settings(plan);
			steady = ($urandom_range(0, 4) == 0);
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				// Pattern change in the middle of a frame takes effect at the next
				// position.
				if (phase_count == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) begin
					settle();
					plan.pattern_second = random_pattern();
					plan.tail_pattern = TAIL_LEN'(random_pattern());
					apply_settings(plan);
				end
				live = frame_open;
				sync = live ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 4) != 0);
				case ($urandom_range(0, 19))
					0: sample = 16'h8000;
					1: sample = 16'h7FFF;
					2: sample = '0;
					3: sample = '1;
					default: sample = SOFT_W'($urandom_range(0, 65535));
				endcase
				send_item(sample, sync);
				if (live || sync)
					phase_count++;
			end
			settle();
			steady = 1'b0;
			counted += PHASE_ITEMS;
		end

		repeat (24) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS msc_depuncturer_unit");
		end else begin
			$display("FAIL msc_depuncturer_unit");
		end
		$finish;
	end

endmodule
